// ===== rtl/luds_pkg.sv =====
package luds_pkg;

  typedef struct packed {
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
  } in_t;

  typedef struct packed {
    logic signed [31:0] norm_x;
    logic signed [31:0] norm_y;
    logic               saturated;
  } out_t;

  typedef enum logic [2:0] {
    REG_PRINCIPAL_POINT = 3'd0,
    REG_FOCAL_X         = 3'd1,
    REG_FOCAL_Y         = 3'd2,
    REG_RADIAL_K1       = 3'd3,
    REG_RADIAL_K2       = 3'd4,
    REG_RADIAL_K3       = 3'd5,
    REG_TANGENTIAL_P1   = 3'd6,
    REG_TANGENTIAL_P2   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] k1;
    logic signed [31:0] k2;
    logic signed [31:0] k3;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
  } coef_t;

  // point state carried from one refinement step to the next
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] xo;
    logic signed [31:0] yo;
    logic               flag;
  } st_t;

  typedef struct packed {
    logic               ovf;
    logic signed [31:0] v;
  } sat_t;

  localparam logic signed [39:0] S32_MAX_W = 40'sd2147483647;
  localparam logic signed [39:0] S32_MIN_W = -40'sd2147483648;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [63:0] HALF_Q28 = 64'sd134217728;
  localparam logic signed [33:0] ONE_Q28 = 34'sd268435456;
  localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

  // round a q56 product to q28, ties toward plus infinity
  function automatic logic signed [35:0] rnd_q28(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p + HALF_Q28;
    return s[63:28];
  endfunction

  function automatic sat_t sat32(input logic signed [39:0] v);
    sat_t r;
    if (v > S32_MAX_W) begin
      r.ovf = 1'b1;
      r.v   = S32_MAX;
    end else if (v < S32_MIN_W) begin
      r.ovf = 1'b1;
      r.v   = S32_MIN;
    end else begin
      r.ovf = 1'b0;
      r.v   = v[31:0];
    end
    return r;
  endfunction

  // sign and clamp an unsigned quotient
  function automatic sat_t fin_q(input logic [31:0] q, input logic neg,
                                 input logic ovf, input logic zero);
    sat_t r;
    if (ovf) begin
      r.ovf = 1'b1;
      r.v   = zero ? 32'sd0 : (neg ? S32_MIN : S32_MAX);
    end else if (neg) begin
      r.ovf = q > NEG_LIMIT;
      r.v   = r.ovf ? S32_MIN : 32'(-q);
    end else begin
      r.ovf = q[31];
      r.v   = q[31] ? S32_MAX : q;
    end
    return r;
  endfunction

endpackage

// ===== rtl/luds_div.sv =====
module luds_div #(
  parameter int DW = 32,
  parameter int QW = 32,
  parameter int SW = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic [1:0][DW-1:0]   num_hi,
  input  logic [1:0][QW-1:0]   num_lo,
  input  logic [1:0][DW-1:0]   den,
  input  logic [SW-1:0]        in_side,
  output logic                 out_vld,
  output logic [1:0][QW-1:0]   quo,
  output logic [SW-1:0]        out_side
);

  logic                 vld_r  [QW];
  logic [1:0][DW-1:0]   rem_r  [QW];
  logic [1:0][QW-1:0]   nq_r   [QW];
  logic [1:0][DW-1:0]   den_r  [QW];
  logic [SW-1:0]        side_r [QW];

  // one quotient bit per stage, both lanes side by side
  for (genvar s = 0; s < QW; s++) begin : g_st
    logic               vld_i;
    logic [1:0][DW-1:0] rem_i;
    logic [1:0][QW-1:0] nq_i;
    logic [1:0][DW-1:0] den_i;
    logic [SW-1:0]      side_i;
    logic [1:0][DW:0]   t;
    logic [1:0]         ge;
    logic [1:0][DW-1:0] rem_n;
    logic [1:0][QW-1:0] nq_n;

    if (s == 0) begin : g_first
      assign vld_i  = in_vld;
      assign rem_i  = num_hi;
      assign nq_i   = num_lo;
      assign den_i  = den;
      assign side_i = in_side;
    end else begin : g_next
      assign vld_i  = vld_r[s-1];
      assign rem_i  = rem_r[s-1];
      assign nq_i   = nq_r[s-1];
      assign den_i  = den_r[s-1];
      assign side_i = side_r[s-1];
    end

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        t[l]     = {rem_i[l], nq_i[l][QW-1]};
        ge[l]    = t[l] >= {1'b0, den_i[l]};
        rem_n[l] = ge[l] ? DW'(t[l] - {1'b0, den_i[l]}) : DW'(t[l]);
        nq_n[l]  = {nq_i[l][QW-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s]  <= rem_n;
      nq_r[s]   <= nq_n;
      den_r[s]  <= den_i;
      side_r[s] <= side_i;
    end
  end

  assign out_vld  = vld_r[QW-1];
  assign quo      = nq_r[QW-1];
  assign out_side = side_r[QW-1];

endmodule

// ===== rtl/luds_norm.sv =====
module luds_norm (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  luds_pkg::in_t in_req,
  input  logic [31:0]   pp,
  input  logic [19:0]   fx,
  input  logic [19:0]   fy,
  output logic          out_vld,
  output luds_pkg::st_t out_st
);
  import luds_pkg::*;

  typedef struct packed {
    logic [1:0] neg;
    logic [1:0] ovf;
    logic [1:0] zero;
  } nside_t;

  localparam int SW = $bits(nside_t);

  logic               vld0_r;
  logic signed [16:0] dx_r, dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else begin
      vld0_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    dx_r <= signed'({1'b0, in_req.pixel_x}) - signed'({1'b0, pp[15:0]});
    dy_r <= signed'({1'b0, in_req.pixel_y}) - signed'({1'b0, pp[31:16]});
  end

  logic [1:0][19:0] num_hi, den;
  logic [1:0][31:0] num_lo, quo;
  logic [1:0][15:0] mag;
  logic [1:0][19:0] hi;
  nside_t           sd_in, sd_out;
  logic             dv_vld;

  always_comb begin
    sd_in.neg[0] = dx_r[16];
    sd_in.neg[1] = dy_r[16];
    mag[0] = dx_r[16] ? 16'(-dx_r) : dx_r[15:0];
    mag[1] = dy_r[16] ? 16'(-dy_r) : dy_r[15:0];
    den[0] = fx;
    den[1] = fy;
    for (int l = 0; l < 2; l++) begin
      hi[l]         = {4'b0, mag[l]};
      sd_in.ovf[l]  = hi[l] >= den[l];
      sd_in.zero[l] = mag[l] == 16'd0;
      num_hi[l]     = sd_in.ovf[l] ? 20'd0 : hi[l];
      num_lo[l]     = 32'd0;
    end
  end

  luds_div #(.DW(20), .QW(32), .SW(SW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (vld0_r),
    .num_hi   (num_hi),
    .num_lo   (num_lo),
    .den      (den),
    .in_side  (sd_in),
    .out_vld  (dv_vld),
    .quo      (quo),
    .out_side (sd_out)
  );

  sat_t  fxs, fys;
  st_t   st_nxt;
  st_t   st_r;
  logic  vld_r;

  always_comb begin
    fxs = fin_q(quo[0], sd_out.neg[0], sd_out.ovf[0], sd_out.zero[0]);
    fys = fin_q(quo[1], sd_out.neg[1], sd_out.ovf[1], sd_out.zero[1]);
    st_nxt.x    = fxs.v;
    st_nxt.y    = fys.v;
    st_nxt.xo   = fxs.v;
    st_nxt.yo   = fys.v;
    st_nxt.flag = fxs.ovf | fys.ovf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
  end

  assign out_vld = vld_r;
  assign out_st  = st_r;

endmodule

// ===== rtl/luds_iter.sv =====
module luds_iter (
  input  logic            clk,
  input  logic            rst_n,
  input  luds_pkg::coef_t coef,
  input  logic            in_vld,
  input  luds_pkg::st_t   in_st,
  output logic            out_vld,
  output luds_pkg::st_t   out_st
);
  import luds_pkg::*;

  typedef struct packed {
    st_t        st;
    logic       dpos;
    logic [1:0] neg;
    logic [1:0] ovf;
    logic [1:0] zero;
  } dside_t;

  localparam int SW = $bits(dside_t);

  // valid bits for stages a..h
  logic [7:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[6:0], in_vld};
    end
  end

  // stage a: squares and cross product
  st_t                a_st_r;
  logic signed [63:0] a_pxx_r, a_pyy_r, a_pxy_r;

  always_ff @(posedge clk) begin
    a_st_r  <= in_st;
    a_pxx_r <= in_st.x * in_st.x;
    a_pyy_r <= in_st.y * in_st.y;
    a_pxy_r <= in_st.x * in_st.y;
  end

  // stage b: r2 and 2xy
  sat_t               b_xx, b_yy, b_xy, b_r2, b_2xy;
  st_t                b_st_nxt, b_st_r;
  logic signed [31:0] b_xx_r, b_yy_r, b_r2_r, b_2xy_r;

  always_comb begin
    b_xx  = sat32(40'(rnd_q28(a_pxx_r)));
    b_yy  = sat32(40'(rnd_q28(a_pyy_r)));
    b_xy  = sat32(40'(rnd_q28(a_pxy_r)));
    b_r2  = sat32(40'(b_xx.v) + 40'(b_yy.v));
    b_2xy = sat32(40'(b_xy.v) + 40'(b_xy.v));
    b_st_nxt      = a_st_r;
    b_st_nxt.flag = a_st_r.flag | b_xx.ovf | b_yy.ovf | b_xy.ovf | b_r2.ovf | b_2xy.ovf;
  end

  always_ff @(posedge clk) begin
    b_st_r  <= b_st_nxt;
    b_xx_r  <= b_xx.v;
    b_yy_r  <= b_yy.v;
    b_r2_r  <= b_r2.v;
    b_2xy_r <= b_2xy.v;
  end

  // stage c: first radial product, tangential cross products
  sat_t               c_ex, c_ey;
  st_t                c_st_nxt, c_st_r;
  logic signed [63:0] c_pk3_r, c_pdxa_r, c_pdya_r;
  logic signed [31:0] c_ex_r, c_ey_r, c_r2_r;

  always_comb begin
    c_ex = sat32(40'(b_r2_r) + 40'(b_xx_r) + 40'(b_xx_r));
    c_ey = sat32(40'(b_r2_r) + 40'(b_yy_r) + 40'(b_yy_r));
    c_st_nxt      = b_st_r;
    c_st_nxt.flag = b_st_r.flag | c_ex.ovf | c_ey.ovf;
  end

  always_ff @(posedge clk) begin
    c_st_r   <= c_st_nxt;
    c_pk3_r  <= coef.k3 * b_r2_r;
    c_pdxa_r <= coef.p1 * b_2xy_r;
    c_pdya_r <= coef.p2 * b_2xy_r;
    c_ex_r   <= c_ex.v;
    c_ey_r   <= c_ey.v;
    c_r2_r   <= b_r2_r;
  end

  // stage d
  sat_t               d_t1;
  st_t                d_st_nxt, d_st_r;
  logic signed [31:0] d_t1_r, d_r2_r;
  logic signed [63:0] d_pdxb_r, d_pdyb_r;
  logic signed [35:0] d_dxa_r, d_dya_r;

  always_comb begin
    d_t1 = sat32(40'(rnd_q28(c_pk3_r)) + 40'(coef.k2));
    d_st_nxt      = c_st_r;
    d_st_nxt.flag = c_st_r.flag | d_t1.ovf;
  end

  always_ff @(posedge clk) begin
    d_st_r   <= d_st_nxt;
    d_t1_r   <= d_t1.v;
    d_r2_r   <= c_r2_r;
    d_pdxb_r <= coef.p2 * c_ex_r;
    d_pdyb_r <= coef.p1 * c_ey_r;
    d_dxa_r  <= rnd_q28(c_pdxa_r);
    d_dya_r  <= rnd_q28(c_pdya_r);
  end

  // stage e
  sat_t               e_dx, e_dy;
  st_t                e_st_nxt, e_st_r;
  logic signed [63:0] e_pt_r;
  logic signed [31:0] e_r2_r, e_dx_r, e_dy_r;

  always_comb begin
    e_dx = sat32(40'(d_dxa_r) + 40'(rnd_q28(d_pdxb_r)));
    e_dy = sat32(40'(d_dya_r) + 40'(rnd_q28(d_pdyb_r)));
    e_st_nxt      = d_st_r;
    e_st_nxt.flag = d_st_r.flag | e_dx.ovf | e_dy.ovf;
  end

  always_ff @(posedge clk) begin
    e_st_r <= e_st_nxt;
    e_pt_r <= d_t1_r * d_r2_r;
    e_r2_r <= d_r2_r;
    e_dx_r <= e_dx.v;
    e_dy_r <= e_dy.v;
  end

  // stage f
  sat_t               f_t2;
  st_t                f_st_nxt, f_st_r;
  logic signed [31:0] f_t2_r, f_r2_r, f_dx_r, f_dy_r;

  always_comb begin
    f_t2 = sat32(40'(rnd_q28(e_pt_r)) + 40'(coef.k1));
    f_st_nxt      = e_st_r;
    f_st_nxt.flag = e_st_r.flag | f_t2.ovf;
  end

  always_ff @(posedge clk) begin
    f_st_r <= f_st_nxt;
    f_t2_r <= f_t2.v;
    f_r2_r <= e_r2_r;
    f_dx_r <= e_dx_r;
    f_dy_r <= e_dy_r;
  end

  // stage g
  st_t                g_st_r;
  logic signed [63:0] g_pt_r;
  logic signed [31:0] g_dx_r, g_dy_r;

  always_ff @(posedge clk) begin
    g_st_r <= f_st_r;
    g_pt_r <= f_t2_r * f_r2_r;
    g_dx_r <= f_dx_r;
    g_dy_r <= f_dy_r;
  end

  // stage h: divisor and numerators
  sat_t               h_t3;
  logic signed [33:0] h_d;
  st_t                h_st_nxt, h_st_r;
  logic [31:0]        h_den_r;
  logic               h_dpos_r;
  logic signed [32:0] h_nx_r, h_ny_r;

  always_comb begin
    h_t3 = sat32(40'(rnd_q28(g_pt_r)));
    h_d  = ONE_Q28 + 34'(h_t3.v);
    h_st_nxt      = g_st_r;
    h_st_nxt.flag = g_st_r.flag | h_t3.ovf;
  end

  always_ff @(posedge clk) begin
    h_st_r   <= h_st_nxt;
    h_den_r  <= h_d[31:0];
    h_dpos_r <= !h_d[33] && (h_d != 34'sd0);
    h_nx_r   <= 33'(g_st_r.xo) - 33'(g_dx_r);
    h_ny_r   <= 33'(g_st_r.yo) - 33'(g_dy_r);
  end

  // divider setup
  logic [1:0][31:0] num_hi, num_lo, den, quo, mag, hi;
  logic [1:0][32:0] nn;
  dside_t           sd_in, sd_out;
  logic             dv_vld;

  always_comb begin
    nn[0] = h_nx_r;
    nn[1] = h_ny_r;
    sd_in.st   = h_st_r;
    sd_in.dpos = h_dpos_r;
    for (int l = 0; l < 2; l++) begin
      sd_in.neg[l]  = nn[l][32];
      mag[l]        = nn[l][32] ? 32'(-nn[l]) : nn[l][31:0];
      den[l]        = h_dpos_r ? h_den_r : 32'd1;
      hi[l]         = {4'b0, mag[l][31:4]};
      sd_in.ovf[l]  = hi[l] >= den[l];
      sd_in.zero[l] = mag[l] == 32'd0;
      num_hi[l]     = sd_in.ovf[l] ? 32'd0 : hi[l];
      num_lo[l]     = {mag[l][3:0], 28'b0};
    end
  end

  luds_div #(.DW(32), .QW(32), .SW(SW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (vld_r[7]),
    .num_hi   (num_hi),
    .num_lo   (num_lo),
    .den      (den),
    .in_side  (sd_in),
    .out_vld  (dv_vld),
    .quo      (quo),
    .out_side (sd_out)
  );

  // final update
  sat_t fxs, fys;
  st_t  st_nxt, st_r;
  logic vo_r;

  always_comb begin
    fxs    = fin_q(quo[0], sd_out.neg[0], sd_out.ovf[0], sd_out.zero[0]);
    fys    = fin_q(quo[1], sd_out.neg[1], sd_out.ovf[1], sd_out.zero[1]);
    st_nxt = sd_out.st;
    if (sd_out.dpos) begin
      st_nxt.x    = fxs.v;
      st_nxt.y    = fys.v;
      st_nxt.flag = sd_out.st.flag | fxs.ovf | fys.ovf;
    end else begin
      st_nxt.flag = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else begin
      vo_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
  end

  assign out_vld = vo_r;
  assign out_st  = st_r;

endmodule

// ===== rtl/lens_undistort_deproject_unit.sv =====
// lens undistortion and deprojection, inverse brown-conrady model
// input: pulse start with a pixel coordinate on in_req (q12.4 x and y);
//   the request is taken at any clock edge where start is high and busy is
//   low. busy is always low: one request can enter on every clock.
// output: out_strobe is high for one cycle with out_result, holding the
//   undistorted normalized x and y in q4.28 and the saturated flag.
//   results come out in request order, one per request.
// pipeline: built around the 32-stage bit-per-stage dividers, one at the
//   front and one in each refinement step.
// throughput: one request per cycle.
// configuration: cfg_wr_en, cfg_index, cfg_wdata write one register per
//   clock; only write while no request is in flight.
// reset: rst_n low clears all in-flight requests and loads the default
//   registers (center 320,240, focal 640, no distortion).
// the receiver cannot stall; results are never held back.
module lens_undistort_deproject_unit #(
  parameter int ITERATIONS = 10
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  luds_pkg::in_t  in_req,
  output logic           out_strobe,
  output luds_pkg::out_t out_result,
  input  logic           cfg_wr_en,
  input  logic [2:0]     cfg_index,
  input  logic [31:0]    cfg_wdata
);
  import luds_pkg::*;

  logic [31:0] pp_r;
  logic [19:0] fx_r, fy_r;
  coef_t       coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_r   <= 32'h0F00_1400;
      fx_r   <= 20'd163840;
      fy_r   <= 20'd163840;
      coef_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PRINCIPAL_POINT: pp_r      <= cfg_wdata;
        REG_FOCAL_X:         fx_r      <= cfg_wdata[19:0];
        REG_FOCAL_Y:         fy_r      <= cfg_wdata[19:0];
        REG_RADIAL_K1:       coef_r.k1 <= cfg_wdata;
        REG_RADIAL_K2:       coef_r.k2 <= cfg_wdata;
        REG_RADIAL_K3:       coef_r.k3 <= cfg_wdata;
        REG_TANGENTIAL_P1:   coef_r.p1 <= cfg_wdata;
        REG_TANGENTIAL_P2:   coef_r.p2 <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic chain_vld [ITERATIONS+1];
  st_t  chain_st  [ITERATIONS+1];

  luds_norm u_norm (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (start & ~busy),
    .in_req  (in_req),
    .pp      (pp_r),
    .fx      (fx_r),
    .fy      (fy_r),
    .out_vld (chain_vld[0]),
    .out_st  (chain_st[0])
  );

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
    luds_iter u_iter (
      .clk     (clk),
      .rst_n   (rst_n),
      .coef    (coef_r),
      .in_vld  (chain_vld[i]),
      .in_st   (chain_st[i]),
      .out_vld (chain_vld[i+1]),
      .out_st  (chain_st[i+1])
    );
  end

  assign out_strobe           = chain_vld[ITERATIONS];
  assign out_result.norm_x    = chain_st[ITERATIONS].x;
  assign out_result.norm_y    = chain_st[ITERATIONS].y;
  assign out_result.saturated = chain_st[ITERATIONS].flag;

endmodule
